>>> rtl/sqpi_pkg.sv
package sqpi_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SlotW = 5;
  localparam int unsigned DistW = 31;
  localparam logic [DistW-1:0] DistMax = 31'h7FFF_FFFF;
  localparam int unsigned ResultLimit = 32;
  localparam int unsigned NresW = 6;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

endpackage

>>> rtl/sqpi_if.sv
interface sqpi_req_if;
  import sqpi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [DataW-1:0] query_distance;
  logic signed [DataW-1:0] point_x;
  logic signed [DataW-1:0] point_y;
  logic signed [DataW-1:0] point_height;
  logic signed [DataW-1:0] point_speed;
  logic                    first_point;

  modport source (output valid, cmd, query_distance, point_x, point_y, point_height,
                  point_speed, first_point, input ready);
  modport sink (input valid, cmd, query_distance, point_x, point_y, point_height,
                point_speed, first_point, output ready);
endinterface

interface sqpi_rsp_if;
  import sqpi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [SlotW-1:0]        slot;
  logic signed [DataW-1:0] speed_at_query;
  logic signed [DataW-1:0] height_at_query;
  logic                    last;

  modport source (output valid, slot, speed_at_query, height_at_query, last, input ready);
  modport sink (input valid, slot, speed_at_query, height_at_query, last, output ready);
endinterface

>>> rtl/sqpi_ram.sv
module sqpi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic [Width-1:0]        wdata_i,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/sqpi_iter.sv
module sqpi_iter
  import sqpi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iter_ctrl_t       ctrl_i,
  input  logic [63:0]      opa_i,
  input  logic [DistW-1:0] den_i,
  output iter_stat_t       stat_o,
  output logic [33:0]      res_o,
  output logic [35:0]      rem_o
);
  logic        busy_q, busy_d, done_q, done_d;
  iter_op_e    op_q, op_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d;
  logic [35:0] rem_q, rem_d;
  logic [33:0] res_q, res_d;
  logic [35:0] rs_sqrt, trial, rs_div;
  logic        ge;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    op_d    = op_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    res_d   = res_q;
    rs_sqrt = {rem_q[33:0], acc_q[63:62]};
    trial   = {2'b00, res_q[31:0], 2'b01};
    rs_div  = {rem_q[34:0], acc_q[63]};
    ge      = 1'b0;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      op_d   = ctrl_i.op;
      res_d  = '0;
      if (ctrl_i.op == OP_SQRT) begin
        acc_d = opa_i;
        rem_d = '0;
        cnt_d = 6'd32;
      end else begin
        // The quotient fits in 34 bits, so the top 30 dividend bits start below den.
        acc_d = {opa_i[33:0], 30'd0};
        rem_d = {6'd0, opa_i[63:34]};
        cnt_d = 6'd34;
      end
    end else if (busy_q) begin
      if (op_q == OP_SQRT) begin
        ge    = (rs_sqrt >= trial);
        rem_d = ge ? rs_sqrt - trial : rs_sqrt;
        acc_d = {acc_q[61:0], 2'b00};
      end else begin
        ge    = (rs_div >= {5'd0, den_i});
        rem_d = ge ? rs_div - {5'd0, den_i} : rs_div;
        acc_d = {acc_q[62:0], 1'b0};
      end
      res_d = {res_q[32:0], ge};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_SQRT;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = res_q;
  assign rem_o       = rem_q;
endmodule

>>> rtl/sorted_query_path_interpolator.sv
// Channel | Dir | Handshake          | Payload
// req_i   | in  | valid/ready        | cmd, query_distance, point_*, first_point
// rsp_o   | out | valid/ready        | slot, speed_at_query, height_at_query, last
//
// A query load walks down the stored entries, moving each larger entry up one place, and
// stops at the first smaller or equal entry, which stays below it. A first point
// restarts the path and its query cursor. Any other point runs a 32-step square root for
// its length (skipped when a coordinate step saturates it), then up to two 34-step
// divisions per served query, all through the one shared iterative unit. The block
// takes no transaction until the current one is finished; a stalled result register
// holds the sequencer. Reset clears all control state; the query memory is not cleared.
module sorted_query_path_interpolator
  import sqpi_pkg::*;
#(
  parameter int unsigned MAX_QUERIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sqpi_req_if.sink    req_i,
  sqpi_rsp_if.source  rsp_o
);
  localparam int unsigned IdxW = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_QUERIES + 1);
  localparam int unsigned EntW = DataW + SlotW;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LD_RD    = 4'd1;
  localparam logic [3:0] ST_LD_CMP   = 4'd2;
  localparam logic [3:0] ST_SQ_X     = 4'd3;
  localparam logic [3:0] ST_SQ_Y     = 4'd4;
  localparam logic [3:0] ST_GO       = 4'd5;
  localparam logic [3:0] ST_WAIT     = 4'd6;
  localparam logic [3:0] ST_SEG      = 4'd7;
  localparam logic [3:0] ST_Q_RD     = 4'd8;
  localparam logic [3:0] ST_Q_CHK    = 4'd9;
  localparam logic [3:0] ST_MUL      = 4'd10;
  localparam logic [3:0] ST_PEEK     = 4'd11;
  localparam logic [3:0] ST_PEEK_CHK = 4'd12;
  localparam logic [3:0] ST_EMIT     = 4'd13;
  localparam logic [3:0] ST_FIN      = 4'd14;

  logic [3:0]              state_q, state_d;
  logic [CntW-1:0]         count_q, count_d, nq_q, nq_d;
  logic [NresW-1:0]        nres_q, nres_d;
  logic                    open_q, open_d;
  logic [DistW-1:0]        dist_q, dist_d;
  logic signed [DataW-1:0] prv_x_q, prv_y_q, prv_h_q, prv_v_q;
  logic signed [DataW-1:0] prv_x_d, prv_y_d, prv_h_d, prv_v_d;
  logic signed [DataW-1:0] cur_x_q, cur_y_q, cur_h_q, cur_v_q;
  logic                    cur_load;
  logic signed [DataW-1:0] ld_dist_q, ld_dist_d;
  logic [SlotW-1:0]        ld_slot_q, ld_slot_d;
  logic [IdxW-1:0]         ld_idx_q, ld_idx_d;
  logic                    sat_q, sat_d;
  logic [DistW-1:0]        len_q, len_d, s2_q, s2_d, den_q, den_d;
  logic [63:0]             pa_q, pa_d, pb_q, pb_d;
  logic [DistW-1:0]        num_q, num_d;
  logic                    neg_q, neg_d, sel_h_q, sel_h_d, is_sqrt_q, is_sqrt_d;
  logic                    last_q, last_d;
  logic [SlotW-1:0]        slot_q, slot_d;
  logic signed [DataW-1:0] spd_q, spd_d, hgt_q, hgt_d;

  logic                    out_valid_q, out_valid_d;
  logic [SlotW-1:0]        out_slot_q;
  logic signed [DataW-1:0] out_spd_q, out_hgt_q;
  logic                    out_last_q, out_load;

  logic                    ram_we, ram_re;
  logic [IdxW-1:0]         ram_waddr, ram_raddr;
  logic [EntW-1:0]         ram_wdata, ram_rdata;
  logic signed [DataW-1:0] ent_dist;

  iter_ctrl_t              it_ctrl;
  iter_stat_t              it_stat;
  logic [63:0]             it_opa;
  logic [33:0]             it_res;
  logic [35:0]             it_rem;

  logic [32:0]             mul_a;
  logic [31:0]             mul_b;
  logic [64:0]             mul_p;
  logic signed [32:0]      dx, dy, diff;
  logic [32:0]             ax, ay, mag;
  logic signed [DataW-1:0] v0, v2, res_val;
  logic [32:0]             root_rnd;
  logic [31:0]             seg_sum;
  logic [CntW-1:0]         count_eff, nq_next;
  logic [DataW:0]          num_full;

  logic req_acc;

  assign req_acc   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign ent_dist  = ram_rdata[EntW-1:SlotW];

  assign dx   = {cur_x_q[DataW-1], cur_x_q} - {prv_x_q[DataW-1], prv_x_q};
  assign dy   = {cur_y_q[DataW-1], cur_y_q} - {prv_y_q[DataW-1], prv_y_q};
  assign ax   = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay   = dy[32] ? 33'(-dy) : 33'(dy);
  assign v0   = sel_h_q ? prv_h_q : prv_v_q;
  assign v2   = sel_h_q ? cur_h_q : cur_v_q;
  assign diff = {v2[DataW-1], v2} - {v0[DataW-1], v0};
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

  // One multiplier serves the squares and the interpolation products.
  always_comb begin
    mul_a = mag;
    mul_b = {1'b0, num_q};
    if (state_q == ST_SQ_X) begin
      mul_a = ax;
      mul_b = ax[31:0];
    end else if (state_q == ST_SQ_Y) begin
      mul_a = ay;
      mul_b = ay[31:0];
    end
  end
  assign mul_p = mul_a * {1'b0, mul_b};

  assign it_opa = is_sqrt_q ? pa_q + pb_q : pa_q + {34'd0, den_q[DistW-1:1]};
  assign it_ctrl.start = (state_q == ST_GO);
  assign it_ctrl.op    = is_sqrt_q ? OP_SQRT : OP_DIV;

  assign root_rnd = {1'b0, it_res[31:0]} + 33'(it_rem > {4'd0, it_res[31:0]});
  assign seg_sum  = {1'b0, dist_q} + {1'b0, len_q};
  assign res_val  = neg_q ? v0 - DataW'(it_res) : v0 + DataW'(it_res);
  assign count_eff = open_q ? count_q : '0;
  assign nq_next   = nq_q + 1'b1;
  assign num_full  = {ent_dist[DataW-1], ent_dist} - {2'b00, dist_q};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    nq_d      = nq_q;
    nres_d    = nres_q;
    open_d    = open_q;
    dist_d    = dist_q;
    prv_x_d   = prv_x_q;
    prv_y_d   = prv_y_q;
    prv_h_d   = prv_h_q;
    prv_v_d   = prv_v_q;
    cur_load  = 1'b0;
    ld_dist_d = ld_dist_q;
    ld_slot_d = ld_slot_q;
    ld_idx_d  = ld_idx_q;
    sat_d     = sat_q;
    len_d     = len_q;
    s2_d      = s2_q;
    den_d     = den_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    num_d     = num_q;
    neg_d     = neg_q;
    sel_h_d   = sel_h_q;
    is_sqrt_d = is_sqrt_q;
    last_d    = last_q;
    slot_d    = slot_q;
    spd_d     = spd_q;
    hgt_d     = hgt_q;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ld_idx_q;
    ram_raddr = nq_q[IdxW-1:0];
    ram_wdata = {ld_dist_q, ld_slot_q};

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          if (!req_i.cmd) begin
            // A load after a path point starts a new query set.
            count_d = count_eff;
            if (!open_q) begin
              nq_d = '0;
            end
            open_d = 1'b1;
            if (count_eff < CntW'(MAX_QUERIES)) begin
              ld_dist_d = req_i.query_distance;
              ld_slot_d = SlotW'(count_eff);
              ld_idx_d  = IdxW'(count_eff);
              count_d   = count_eff + 1'b1;
              state_d   = ST_LD_RD;
            end
          end else begin
            open_d   = 1'b0;
            cur_load = 1'b1;
            if (req_i.first_point) begin
              dist_d  = '0;
              nq_d    = '0;
              prv_x_d = req_i.point_x;
              prv_y_d = req_i.point_y;
              prv_h_d = req_i.point_height;
              prv_v_d = req_i.point_speed;
            end else begin
              state_d = ST_SQ_X;
            end
          end
        end
      end
      ST_LD_RD: begin
        if (ld_idx_q == '0) begin
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ld_idx_q - 1'b1;
          state_d   = ST_LD_CMP;
        end
      end
      ST_LD_CMP: begin
        ram_we = 1'b1;
        if (ent_dist > ld_dist_q) begin
          ram_wdata = ram_rdata;
          ld_idx_d  = ld_idx_q - 1'b1;
          state_d   = ST_LD_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SQ_X: begin
        sat_d   = (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
        pa_d    = mul_p[63:0];
        state_d = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        pb_d      = mul_p[63:0];
        is_sqrt_d = 1'b1;
        if (sat_q) begin
          len_d   = DistMax;
          state_d = ST_SEG;
        end else begin
          state_d = ST_GO;
        end
      end
      ST_GO: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (it_stat.done) begin
          if (is_sqrt_q) begin
            len_d   = root_rnd[32:31] != 2'b00 ? DistMax : root_rnd[DistW-1:0];
            state_d = ST_SEG;
          end else if (!sel_h_q) begin
            spd_d   = res_val;
            sel_h_d = 1'b1;
            state_d = ST_MUL;
          end else begin
            hgt_d   = res_val;
            state_d = ST_PEEK;
          end
        end
      end
      ST_SEG: begin
        s2_d    = seg_sum[31] ? DistMax : seg_sum[DistW-1:0];
        den_d   = (seg_sum[31] ? DistMax : seg_sum[DistW-1:0]) - dist_q;
        nres_d  = '0;
        state_d = ST_Q_RD;
      end
      ST_Q_RD: begin
        if (nq_q < count_q) begin
          ram_re  = 1'b1;
          state_d = ST_Q_CHK;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_Q_CHK: begin
        if (ent_dist > $signed({1'b0, s2_q})) begin
          state_d = ST_FIN;
        end else begin
          // A query before the segment start is served at the start.
          num_d   = num_full[DataW] ? '0 : num_full[DistW-1:0];
          slot_d  = ram_rdata[SlotW-1:0];
          sel_h_d = 1'b0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        neg_d     = diff[32];
        pa_d      = mul_p[63:0];
        is_sqrt_d = 1'b0;
        if (den_q == '0) begin
          if (!sel_h_q) begin
            spd_d   = v0;
            sel_h_d = 1'b1;
          end else begin
            hgt_d   = v0;
            state_d = ST_PEEK;
          end
        end else begin
          state_d = ST_GO;
        end
      end
      ST_PEEK: begin
        if (nq_next < count_q && nres_q < NresW'(ResultLimit - 1)) begin
          ram_re    = 1'b1;
          ram_raddr = nq_next[IdxW-1:0];
          state_d   = ST_PEEK_CHK;
        end else begin
          last_d  = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_PEEK_CHK: begin
        last_d  = ent_dist > $signed({1'b0, s2_q});
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          nq_d     = nq_next;
          nres_d   = nres_q + 1'b1;
          state_d  = last_q ? ST_FIN : ST_Q_CHK;
        end
      end
      ST_FIN: begin
        dist_d  = s2_q;
        prv_x_d = cur_x_q;
        prv_y_d = cur_y_q;
        prv_h_d = cur_h_q;
        prv_v_d = cur_v_q;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      nq_q        <= '0;
      nres_q      <= '0;
      open_q      <= 1'b1;
      dist_q      <= '0;
      prv_x_q     <= '0;
      prv_y_q     <= '0;
      prv_h_q     <= '0;
      prv_v_q     <= '0;
      is_sqrt_q   <= 1'b0;
      sel_h_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      nq_q        <= nq_d;
      nres_q      <= nres_d;
      open_q      <= open_d;
      dist_q      <= dist_d;
      prv_x_q     <= prv_x_d;
      prv_y_q     <= prv_y_d;
      prv_h_q     <= prv_h_d;
      prv_v_q     <= prv_v_d;
      is_sqrt_q   <= is_sqrt_d;
      sel_h_q     <= sel_h_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_load) begin
      cur_x_q <= req_i.point_x;
      cur_y_q <= req_i.point_y;
      cur_h_q <= req_i.point_height;
      cur_v_q <= req_i.point_speed;
    end
    ld_dist_q <= ld_dist_d;
    ld_slot_q <= ld_slot_d;
    ld_idx_q  <= ld_idx_d;
    sat_q     <= sat_d;
    len_q     <= len_d;
    s2_q      <= s2_d;
    den_q     <= den_d;
    pa_q      <= pa_d;
    pb_q      <= pb_d;
    num_q     <= num_d;
    neg_q     <= neg_d;
    slot_q    <= slot_d;
    spd_q     <= spd_d;
    hgt_q     <= hgt_d;
    if (out_load) begin
      out_slot_q <= slot_q;
      out_spd_q  <= spd_q;
      out_hgt_q  <= hgt_q;
      out_last_q <= last_q;
    end
  end

  sqpi_ram #(
    .Width (EntW),
    .Depth (MAX_QUERIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sqpi_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (it_ctrl),
    .opa_i  (it_opa),
    .den_i  (den_q),
    .stat_o (it_stat),
    .res_o  (it_res),
    .rem_o  (it_rem)
  );

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.slot            = out_slot_q;
  assign rsp_o.speed_at_query  = out_spd_q;
  assign rsp_o.height_at_query = out_hgt_q;
  assign rsp_o.last            = out_last_q;

  a_nq_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nq_q <= count_q) else $error("served index beyond stored query count");

  a_count_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_QUERIES)) else $error("query count beyond capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || rsp_o.ready))
    else $error("result register overwritten while stalled");

  a_iter_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_ctrl.start |-> !it_stat.busy) else $error("shared unit started while busy");
endmodule

>>> sim/sqpi_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces are declared in the RTL; this file only gathers the
// transaction type that the driver queue carries and the result type that the monitor expects.
package sqpi_tb_pkg;
  import sqpi_pkg::*;

  typedef struct {
    logic                    cmd;
    logic signed [DataW-1:0] query_distance;
    logic signed [DataW-1:0] point_x;
    logic signed [DataW-1:0] point_y;
    logic signed [DataW-1:0] point_height;
    logic signed [DataW-1:0] point_speed;
    logic                    first_point;
  } path_item_t;

  typedef struct {
    logic [SlotW-1:0]        slot;
    logic signed [DataW-1:0] speed;
    logic signed [DataW-1:0] height;
    logic                    last;
  } query_value_t;
endpackage

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import sqpi_pkg::*;
  import sqpi_tb_pkg::*;

  localparam int MaxQ = 32;
  localparam longint DMax = 64'h7FFF_FFFF;
  localparam longint CycleLimit = 4000000;

  logic clk_i;
  logic rst_ni;

  sqpi_req_if req();
  sqpi_rsp_if rsp();

  sorted_query_path_interpolator #(.MAX_QUERIES(MaxQ)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Predictor state.
  longint      q_dist[MaxQ];
  logic [4:0]  q_slot[MaxQ];
  int          q_count, q_next;
  longint      path_dist;
  longint      prev_x, prev_y, prev_h, prev_v;
  bit          loading_open;

  path_item_t   pending_items[$];
  query_value_t expected_values[$];
  int  sender_idle_pct, receiver_idle_pct;
  int  fail_count;
  longint cycle_count;
  bit  stim_done;

  function automatic void add_item(input path_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic longint isqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'h1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint seg_length(longint dx, longint dy);
    longint unsigned ax, ay, sum, r;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) return DMax;
    sum = ax * ax + ay * ay;
    r = isqrt(sum);
    if (sum - r * r > r) r++;
    if (r > DMax) r = DMax;
    return r;
  endfunction

  function automatic longint lerp(longint v0, longint v2, longint num, longint den);
    longint diff;
    longint unsigned mag, q;
    if (den <= 0) return v0;
    diff = v2 - v0;
    mag = diff < 0 ? -diff : diff;
    q = (mag * num + den / 2) / den;
    return diff < 0 ? v0 - q : v0 + q;
  endfunction

  task automatic predict_item(input path_item_t it);
    longint s0, s2, den, d, num;
    int pos, n;
    query_value_t r;
    if (it.cmd == 1'b0) begin
      if (!loading_open) begin
        q_count = 0;
        q_next = 0;
        loading_open = 1;
      end
      if (q_count >= MaxQ) return;
      pos = 0;
      while (pos < q_count && q_dist[pos] <= longint'(it.query_distance)) pos++;
      for (int i = q_count; i > pos; i--) begin
        q_dist[i] = q_dist[i-1];
        q_slot[i] = q_slot[i-1];
      end
      q_dist[pos] = longint'(it.query_distance);
      q_slot[pos] = q_count[4:0];
      q_count++;
      return;
    end
    loading_open = 0;
    if (it.first_point) begin
      path_dist = 0;
      q_next = 0;
    end else begin
      s0 = path_dist;
      s2 = s0 + seg_length(longint'(it.point_x) - prev_x, longint'(it.point_y) - prev_y);
      if (s2 > DMax) s2 = DMax;
      den = s2 - s0;
      n = 0;
      while (q_next < q_count && n < ResultLimit) begin
        d = q_dist[q_next];
        if (d > s2) break;
        num = (d < s0 ? s0 : d) - s0;
        r.slot = q_slot[q_next];
        r.speed = DataW'(lerp(prev_v, longint'(it.point_speed), num, den));
        r.height = DataW'(lerp(prev_h, longint'(it.point_height), num, den));
        r.last = 0;
        expected_values.insert(expected_values.size(), r);
        n++;
        q_next++;
      end
      if (n > 0) expected_values[$].last = 1;
      path_dist = s2;
    end
    prev_x = longint'(it.point_x);
    prev_y = longint'(it.point_y);
    prev_h = longint'(it.point_height);
    prev_v = longint'(it.point_speed);
  endtask

  function automatic path_item_t mk_load(logic signed [31:0] d);
    path_item_t it;
    it.cmd = 0;
    it.query_distance = d;
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.point_height = $urandom;
    it.point_speed = $urandom;
    it.first_point = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic path_item_t mk_point(logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] h, logic signed [31:0] v,
                                          logic fp);
    path_item_t it;
    it.cmd = 1;
    it.query_distance = $urandom;
    it.point_x = x;
    it.point_y = y;
    it.point_height = h;
    it.point_speed = v;
    it.first_point = fp;
    return it;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: one transaction per handshake, valid held while waiting.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 0;
      req.cmd <= 0;
      req.query_distance <= 0;
      req.point_x <= 0;
      req.point_y <= 0;
      req.point_height <= 0;
      req.point_speed <= 0;
      req.first_point <= 0;
    end else if (!req.valid || req.ready) begin
      if (req.valid && req.ready) predict_item(pending_items.pop_front());
      if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        req.valid <= 1;
        req.cmd <= pending_items[0].cmd;
        req.query_distance <= pending_items[0].query_distance;
        req.point_x <= pending_items[0].point_x;
        req.point_y <= pending_items[0].point_y;
        req.point_height <= pending_items[0].point_height;
        req.point_speed <= pending_items[0].point_speed;
        req.first_point <= pending_items[0].first_point;
      end else begin
        req.valid <= 0;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    query_value_t e;
    if (!rst_ni) begin
      rsp.ready <= 0;
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (rsp.valid && rsp.ready) begin
        if (expected_values.size() == 0) begin
          $error("unexpected transaction slot=%0d", rsp.slot);
          fail_count++;
        end else begin
          e = expected_values.pop_front();
          if (rsp.slot !== e.slot) begin
            $error("slot: expected %0d actual %0d", e.slot, rsp.slot);
            fail_count++;
          end
          if (rsp.speed_at_query !== e.speed) begin
            $error("speed_at_query: expected %0d actual %0d", e.speed, rsp.speed_at_query);
            fail_count++;
          end
          if (rsp.height_at_query !== e.height) begin
            $error("height_at_query: expected %0d actual %0d", e.height,
                   rsp.height_at_query);
            fail_count++;
          end
          if (rsp.last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, rsp.last);
            fail_count++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic add_random_path();
    int nq, np;
    logic signed [31:0] x, y;
    nq = $urandom_range(1, 6);
    if ($urandom_range(9) == 0) nq = $urandom_range(20, 34);
    for (int i = 0; i < nq; i++)
      add_item(mk_load($urandom_range(9) == 0 ? $urandom
                                               : $urandom_range(0, 32'h60000)));
    np = $urandom_range(2, 6);
    x = $urandom_range(0, 32'h10000);
    y = $urandom_range(0, 32'h10000);
    add_item(mk_point(x, y, $urandom, $urandom, $urandom_range(9) != 0));
    for (int i = 1; i < np; i++) begin
      if ($urandom_range(7) != 0) begin
        x += $urandom_range(0, 32'h18000) - 32'h4000;
        y += $urandom_range(0, 32'h18000) - 32'h4000;
      end
      if ($urandom_range(19) == 0) x = $urandom;
      add_item(mk_point(x, y, $urandom, $urandom, $urandom_range(19) == 0));
    end
  endtask

  initial begin
    int base_size;
    q_count = 0; q_next = 0; path_dist = 0;
    prev_x = 0; prev_y = 0; prev_h = 0; prev_v = 0;
    loading_open = 1;
    fail_count = 0;
    stim_done = 0;
    sender_idle_pct = 22;
    receiver_idle_pct = 81;
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: point before any first point from origin, equal distances,
    // queries before start and beyond end, extreme coordinates, zero segment.
    add_item(mk_load(32'sh0002_0000));
    add_item(mk_load(32'sh0001_0000));
    add_item(mk_load(32'sh0001_0000));
    add_item(mk_load(32'sh8000_0000));
    add_item(mk_load(32'sh7FFF_FFFF));
    add_item(mk_point(32'sh0003_0000, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    add_item(mk_point(32'sh0003_0000, 0, 5, 6, 0));
    add_item(mk_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                      32'sh7FFF_FFFF, 0));
    add_item(mk_point(32'sh7FFF_FFFF, 32'sh8000_0000, -1, -1, 0));
    add_item(mk_load(32'sh0000_8000));
    add_item(mk_load(0));
    add_item(mk_point(0, 0, 32'sh0001_0000, 32'sh0002_0000, 1));
    add_item(mk_point(0, 0, 1, 2, 0));
    add_item(mk_point(32'sh0001_0000, 32'sh0001_0000, -3, 7, 0));
    // Over-full set, all served by one point.
    for (int i = 0; i < 34; i++) add_item(mk_load(i * 100));
    add_item(mk_point(0, 0, 0, 0, 1));
    add_item(mk_point(32'sh0010_0000, 0, 32'sh0100_0000, -32'sh100_0000, 0));

    for (int ph = 0; ph < 3; ph++) begin
      base_size = pending_items.size();
      while (pending_items.size() - base_size < 52) begin
        add_random_path();
      end
      wait (pending_items.size() == 0 && !req.valid);
      wait (expected_values.size() == 0);
      if (ph == 0) begin
        sender_idle_pct = 81;
        receiver_idle_pct = 22;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
    end
    repeat (200) @(posedge clk_i);
    stim_done = 1;
  end

  initial begin
    wait (stim_done || cycle_count >= CycleLimit);
    if (!stim_done) begin
      $display("== FAIL ==");
    end else if (fail_count == 0 && expected_values.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/sqpi_pkg.sv
rtl/sqpi_if.sv
rtl/sqpi_ram.sv
rtl/sqpi_iter.sv
rtl/sorted_query_path_interpolator.sv
sim/sqpi_tb_if.sv
sim/tb.sv
